FILE: rtl/core/rwct_pkg.sv
// Shared types and constants for the raycast wall column texturer.
// Used by the controller, datapath, divider and top level; no dependencies.
package rwct_pkg;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_COLUMN = 2'd1;
  localparam logic [1:0] ACT_PIXEL  = 2'd2;

  localparam logic KIND_COLUMN = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  localparam logic [1:0] TEX_NORTH = 2'd0;
  localparam logic [1:0] TEX_SOUTH = 2'd1;
  localparam logic [1:0] TEX_EAST  = 2'd2;
  localparam logic [1:0] TEX_WEST  = 2'd3;

  localparam int TEXTURE_COUNT = 4;
  localparam logic [23:0] HALF_MASK = 24'd8355711;
  localparam logic [10:0] SCREEN_HEIGHT_RESET = 11'd480;
  localparam logic [15:0] LINE_HEIGHT_MAX = 16'hFFFF;

  localparam int IN_W   = 152;
  localparam int OUT_W  = 64;
  localparam int DIV_NW = 25;
  localparam int DIV_DW = 24;
  localparam int DIV_CW = 5;

  typedef struct packed {
    logic load_we;
    logic pix_go;
    logic col_go;
    logic div_go;
    logic div_sel;
    logic lh_latch;
    logic step_latch;
    logic pos_latch;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic slot_free;
    logic emit_ok;
  } status_t;

endpackage

FILE: rtl/core/raycast_wall_column_texturer_unit.sv
// Top level of the raycast wall column texturer: controller plus datapath.
// Depends on rwct_pkg, rwct_ctrl, rwct_datapath (which holds rwct_div, rwct_ram).
//
//   Channel   Dir  Contents
//   s_*       in   requests: tuser = action, tdata = load, column and pixel fields
//   m_*       out  results: tuser = result kind, tdata = heights, rows, colour
//   cfg_*     in   screen height register write, no read-back
//
// Load and pixel requests can stream one per cycle while the controller is idle
// and the pixel slot is free; a pixel result passes through a one-slot read stage
// and then the result register. A column request holds the input through two
// 25-step runs of the shared bit-serial divider, then hand-off, latching and the
// offset multiply; its result is registered once no pixel is pending and the output has room.
// Reset is synchronous; it returns the controller to idle and zeroes texture state.
// While the result register is full and not taken, at most one more pixel waits in
// the read stage; further requests are stalled until the output drains.
module raycast_wall_column_texturer_unit #(
  parameter int TEXTURE_SIZE      = 64,
  parameter int MAX_SCREEN_HEIGHT = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  // Configuration: screen height in rows.
  input  logic                       cfg_we,
  input  logic [10:0]                cfg_wdata,
  // Request channel.
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // tdata from bit 0: texel_address 14, texel_colour 24, wall_distance 24,
  // ray_x 18, ray_y 18, hit_side 1, step_x_positive 1, step_y_positive 1,
  // player_x 22, player_y 22, then zero padding.
  input  logic [rwct_pkg::IN_W-1:0]  s_tdata,
  // tuser: action 2.
  input  logic [1:0]                 s_tuser,
  // Result channel.
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // tdata from bit 0: line_height 16, first_row 10, last_row 10,
  // pixel_colour 24, then zero padding.
  output logic [rwct_pkg::OUT_W-1:0] m_tdata,
  // tuser: result_kind 1.
  output logic                       m_tuser
);

  rwct_pkg::cmd_t    cmd;
  rwct_pkg::status_t status;

  // The controller owns the request handshake and sequences column setup.
  rwct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .action   (s_tuser),
    .status   (status),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  // The datapath holds the texel store, divider, texture state and result register.
  rwct_datapath #(
    .TEXTURE_SIZE      (TEXTURE_SIZE),
    .MAX_SCREEN_HEIGHT (MAX_SCREEN_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

FILE: rtl/core/rwct_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module rwct_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/rwct_div.sv
// Restoring divider, one quotient bit per cycle, shared by both column divisions.
// Depends on rwct_pkg for its widths.
module rwct_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rwct_pkg::DIV_NW-1:0]  num,
  input  logic [rwct_pkg::DIV_DW-1:0]  den,
  output logic                         done,
  output logic [rwct_pkg::DIV_NW-1:0]  quo
);

  logic [rwct_pkg::DIV_DW:0]   rem;
  logic [rwct_pkg::DIV_DW-1:0] dsr;
  logic [rwct_pkg::DIV_CW-1:0] cnt;
  logic                        busy;
  logic [rwct_pkg::DIV_DW:0]   trial;

  assign trial = {rem[rwct_pkg::DIV_DW-1:0], quo[rwct_pkg::DIV_NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= rwct_pkg::DIV_CW'(rwct_pkg::DIV_NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == rwct_pkg::DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dsr <= den;
    end else if (busy) begin
      if (trial >= {1'b0, dsr}) begin
        rem <= trial - {1'b0, dsr};
        quo <= {quo[rwct_pkg::DIV_NW-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[rwct_pkg::DIV_NW-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/core/rwct_ctrl.sv
// Controller state machine: request decode, column sequencing, result timing.
// Depends on rwct_pkg for command and status structs.
module rwct_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic [1:0]          action,
  input  rwct_pkg::status_t   status,
  output logic                s_tready,
  output rwct_pkg::cmd_t      cmd
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_LH_GO   = 7'b0000010,
    S_LH_WAIT = 7'b0000100,
    S_ST_GO   = 7'b0001000,
    S_ST_WAIT = 7'b0010000,
    S_MUL     = 7'b0100000,
    S_EMIT    = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign s_tready = (state == S_IDLE) && status.slot_free;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (action)
            rwct_pkg::ACT_LOAD: cmd.load_we = 1'b1;
            rwct_pkg::ACT_COLUMN: begin
              cmd.col_go = 1'b1;
              state_next = S_LH_GO;
            end
            rwct_pkg::ACT_PIXEL: cmd.pix_go = 1'b1;
            default: ;
          endcase
        end
      end
      S_LH_GO: begin
        cmd.div_go = 1'b1;
        state_next = S_LH_WAIT;
      end
      S_LH_WAIT: begin
        if (status.div_done) begin
          cmd.lh_latch = 1'b1;
          state_next   = S_ST_GO;
        end
      end
      S_ST_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = 1'b1;
        state_next  = S_ST_WAIT;
      end
      S_ST_WAIT: begin
        cmd.div_sel = 1'b1;
        if (status.div_done) begin
          cmd.step_latch = 1'b1;
          state_next     = S_MUL;
        end
      end
      S_MUL: begin
        cmd.pos_latch = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        if (status.emit_ok) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_emit_in_emit_state: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (state == S_EMIT) && status.emit_ok)
    else $error("column result emitted outside its slot");
  a_col_starts_div: assert property (@(posedge clk) disable iff (rst)
    cmd.col_go |=> cmd.div_go && !cmd.div_sel)
    else $error("column did not start line height division");
  a_done_only_waiting: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == S_LH_WAIT) || (state == S_ST_WAIT))
    else $error("divider finished while no division pending");

endmodule

FILE: rtl/core/rwct_datapath.sv
// Datapath: texel store, shared divider, column math, pixel stage, result register.
// Depends on rwct_pkg, rwct_ram and rwct_div.
module rwct_datapath #(
  parameter int TEXTURE_SIZE      = 64,
  parameter int MAX_SCREEN_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [10:0]                   cfg_wdata,
  input  logic [rwct_pkg::IN_W-1:0]     s_tdata,
  input  rwct_pkg::cmd_t                cmd,
  output rwct_pkg::status_t             status,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [rwct_pkg::OUT_W-1:0]    m_tdata,
  output logic                          m_tuser
);

  localparam int TW = $clog2(TEXTURE_SIZE);
  localparam int AW = 2 + 2 * TW;
  localparam int DEPTH = rwct_pkg::TEXTURE_COUNT * TEXTURE_SIZE * TEXTURE_SIZE;
  localparam int XW = (AW > 14) ? AW : 14;

  // Input fields.
  logic [13:0] in_addr;
  logic [23:0] in_colour, in_dist, in_px, in_py;
  logic [17:0] in_rx, in_ry;
  logic        in_side, in_sx, in_sy;
  logic [XW-1:0] addr_ext;

  assign in_addr   = s_tdata[13:0];
  assign in_colour = s_tdata[37:14];
  assign in_dist   = s_tdata[61:38];
  assign in_rx     = s_tdata[79:62];
  assign in_ry     = s_tdata[97:80];
  assign in_side   = s_tdata[98];
  assign in_sx     = s_tdata[99];
  assign in_sy     = s_tdata[100];
  assign in_px     = {2'b0, s_tdata[122:101]};
  assign in_py     = {2'b0, s_tdata[144:123]};
  assign addr_ext  = XW'(in_addr);

  // Configuration and per-column texture state.
  logic [10:0]   screen_height;
  logic [TW-1:0] texture_column;
  logic [31:0]   texture_position;
  logic [31:0]   texture_step;
  logic [1:0]    wall_texture;
  logic          shade_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_height <= rwct_pkg::SCREEN_HEIGHT_RESET;
    end else if (cfg_we) begin
      screen_height <= cfg_wdata;
    end
  end

  // Captured column request.
  logic [10:0] h;
  logic [23:0] col_dist;
  logic [17:0] ray_sel;
  logic [13:0] pos_frac;
  logic        side, mirror;
  logic [1:0]  tex_sel;
  logic [10:0] h_clamp;

  always_comb begin
    h_clamp = screen_height;
    if (screen_height == 11'd0) begin
      h_clamp = 11'd1;
    end else if (32'(screen_height) > MAX_SCREEN_HEIGHT) begin
      h_clamp = 11'(MAX_SCREEN_HEIGHT);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.col_go) begin
      h        <= h_clamp;
      col_dist <= in_dist;
      side     <= in_side;
      ray_sel  <= in_side ? in_rx : in_ry;
      pos_frac <= in_side ? in_px[13:0] : in_py[13:0];
      mirror   <= in_side ? in_ry[17] : (!in_rx[17] && (in_rx != 18'd0));
      if (in_side) begin
        tex_sel <= in_sy ? rwct_pkg::TEX_NORTH : rwct_pkg::TEX_SOUTH;
      end else begin
        tex_sel <= in_sx ? rwct_pkg::TEX_EAST : rwct_pkg::TEX_WEST;
      end
    end
  end

  // Wall hit fraction: only the low 28 bits of the Q.28 product matter.
  logic [42:0] hit_prod;
  logic [27:0] frac;
  logic [TW-1:0] col_raw;

  always_ff @(posedge clk) begin
    hit_prod <= 43'($signed({1'b0, col_dist}) * $signed(ray_sel));
  end

  assign frac    = {pos_frac, 14'b0} + hit_prod[27:0];
  assign col_raw = frac[27 -: TW];

  // Shared divider.
  logic                        div_done;
  logic [rwct_pkg::DIV_NW-1:0] div_quo, div_num;
  logic [rwct_pkg::DIV_DW-1:0] div_den;
  logic [15:0]                 lh;

  assign div_num = cmd.div_sel ? (rwct_pkg::DIV_NW'(TEXTURE_SIZE) << 16)
                               : {h, 14'b0};
  assign div_den = cmd.div_sel ? {8'b0, lh} : col_dist;

  rwct_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.lh_latch) begin
      if (div_quo > rwct_pkg::DIV_NW'(rwct_pkg::LINE_HEIGHT_MAX)) begin
        lh <= rwct_pkg::LINE_HEIGHT_MAX;
      end else if (div_quo == '0) begin
        lh <= 16'd1;
      end else begin
        lh <= div_quo[15:0];
      end
    end
  end

  // Row bounds and starting texture offset.
  logic [9:0]  hh;
  logic [14:0] lh2;
  logic [9:0]  first_row;
  logic [15:0] last_sum;
  logic [10:0] h_m1;
  logic [10:0] last_full;
  logic [14:0] offset;

  assign hh       = h[10:1];
  assign lh2      = lh[15:1];
  assign first_row = ({5'b0, hh} >= lh2) ? 10'(hh - 10'(lh2)) : 10'd0;
  assign last_sum = 16'(hh) + 16'(lh2);
  assign h_m1     = h - 11'd1;
  assign last_full = (last_sum > 16'(h_m1)) ? h_m1 : last_sum[10:0];
  assign offset   = (lh2 > {5'b0, hh}) ? (lh2 - {5'b0, hh}) : 15'd0;

  // Texel store.
  logic [AW-1:0] rd_addr;
  logic [23:0]   rd_data;

  assign rd_addr = {wall_texture, texture_position[16 +: TW], texture_column};

  rwct_ram #(
    .WIDTH (24),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load_we),
    .waddr (addr_ext[AW-1:0]),
    .wdata (in_colour),
    .re    (cmd.pix_go),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      texture_column   <= '0;
      texture_position <= '0;
      texture_step     <= '0;
      wall_texture     <= rwct_pkg::TEX_NORTH;
      shade_flag       <= 1'b0;
    end else begin
      if (cmd.pix_go) begin
        texture_position <= texture_position + texture_step;
      end
      if (cmd.step_latch) begin
        texture_step <= 32'(div_quo);
      end
      if (cmd.pos_latch) begin
        texture_position <= 32'(offset * texture_step);
      end
      if (cmd.emit) begin
        texture_column <= mirror ? ~col_raw : col_raw;
        wall_texture   <= tex_sel;
        shade_flag     <= side;
      end
    end
  end

  // Pixel stage waits on the registered texel read, then moves to the result register.
  logic p_valid, p_shade, out_free, p_move;
  logic [23:0] pix;

  assign out_free = !m_tvalid || m_tready;
  assign p_move   = p_valid && out_free;
  assign pix      = p_shade ? ((rd_data >> 1) & rwct_pkg::HALF_MASK) : rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (cmd.pix_go) begin
      p_valid <= 1'b1;
    end else if (p_move) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_go) begin
      p_shade <= shade_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (p_move || cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      m_tuser <= rwct_pkg::KIND_PIXEL;
      m_tdata <= {4'b0, pix, 36'b0};
    end else if (cmd.emit) begin
      m_tuser <= rwct_pkg::KIND_COLUMN;
      m_tdata <= {28'b0, last_full[9:0], first_row, lh};
    end
  end

  assign status.div_done  = div_done;
  assign status.slot_free = !p_valid || out_free;
  assign status.emit_ok   = !p_valid && out_free;

  a_emit_no_pixel: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !p_valid)
    else $error("column result would overtake a pending pixel");
  a_column_lh_nonzero: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.emit) |-> m_tvalid && m_tdata[15:0] != 16'd0)
    else $error("column result with zero line height");
  a_pixel_lands: assert property (@(posedge clk) disable iff (rst)
    cmd.pix_go |=> p_valid)
    else $error("pixel request lost before texel read");

endmodule
